[hw/rtl/hrd_pkg.sv]
// Shared types and constants for the H.265 RTP depacketizer.
// No dependencies; used by every module of the block.
package hrd_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] seq_num;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       nal_begin;
    logic       nal_finish;
    logic       nal_abort;
    logic       last;
  } out_t;

  // Result slots of one request, emitted lowest first.
  localparam int unsigned NumSlots  = 8;
  localparam int unsigned SlotPre   = 0;
  localparam int unsigned SlotSc0   = 1;
  localparam int unsigned SlotSc3   = 4;
  localparam int unsigned SlotByte0 = 5;
  localparam int unsigned SlotByte1 = 6;
  localparam int unsigned SlotPost  = 7;

  typedef struct packed {
    logic [NumSlots-1:0] slots;
    logic [7:0]          byte0;
    logic [7:0]          byte1;
    logic                finish;
  } desc_t;

  localparam logic [5:0] TypeAggr = 6'd48;
  localparam logic [5:0] TypeFrag = 6'd49;
  localparam logic [7:0] HdrKeepMask = 8'h81;
  localparam logic [7:0] StartCodeLast = 8'h01;

  typedef enum logic [14:0] {
    PH_IDLE       = 15'h0001,
    PH_SINGLE     = 15'h0002,
    PH_AP_HDR1    = 15'h0004,
    PH_AP_NEXT    = 15'h0008,
    PH_AP_DONL_LO = 15'h0010,
    PH_AP_SIZE_HI = 15'h0020,
    PH_AP_SIZE_LO = 15'h0040,
    PH_AP_NAL     = 15'h0080,
    PH_FU_HDR1    = 15'h0100,
    PH_FU_HEADER  = 15'h0200,
    PH_FU_DONL_HI = 15'h0400,
    PH_FU_DONL_LO = 15'h0800,
    PH_FU_FIRST   = 15'h1000,
    PH_FU_DATA    = 15'h2000,
    PH_SKIP       = 15'h4000
  } phase_t;

endpackage

[hw/rtl/hrd_parser.sv]
// Input register and packet parser: turns one payload byte into a result descriptor.
// Depends on hrd_pkg.
module hrd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          pkt_valid,
  output logic          pkt_stall,
  input  hrd_pkg::in_t  pkt,
  input  logic          ready,
  output hrd_pkg::desc_t desc
);

  logic               donl_enabled;
  logic               in_valid;
  hrd_pkg::in_t       in_r;
  hrd_pkg::phase_t    parse_phase, parse_phase_next;
  logic [15:0]        nal_bytes_left, nal_bytes_left_next;
  logic [7:0]         size_high_byte, size_high_byte_next;
  logic [7:0]         payload_header_first, payload_header_first_next;
  logic               fragment_end_seen, fragment_end_seen_next;
  logic               nal_open, nal_open_next;
  logic               fragment_run_dropped, fragment_run_dropped_next;
  logic [15:0]        previous_seq, previous_seq_next;
  hrd_pkg::desc_t     d;
  logic               move;

  assign move      = in_valid && ready;
  assign pkt_stall = in_valid && !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      donl_enabled <= 1'b0;
    end else if (cfg_we) begin
      donl_enabled <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pkt_valid && !pkt_stall) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && !pkt_stall) begin
      in_r <= pkt;
    end
  end

  always_comb begin
    logic [5:0]      ptype;
    logic [15:0]     size;
    logic            pre_abort;
    logic            post_abort;
    logic            sc;
    logic [1:0]      nbytes;
    hrd_pkg::phase_t fu_next;

    ptype   = in_r.data_byte[6:1];
    size    = {size_high_byte, in_r.data_byte};
    fu_next = donl_enabled ? hrd_pkg::PH_FU_DONL_HI : hrd_pkg::PH_FU_FIRST;

    parse_phase_next          = parse_phase;
    nal_bytes_left_next       = nal_bytes_left;
    size_high_byte_next       = size_high_byte;
    payload_header_first_next = payload_header_first;
    fragment_end_seen_next    = fragment_end_seen;
    nal_open_next             = nal_open;
    fragment_run_dropped_next = fragment_run_dropped;
    previous_seq_next         = previous_seq;
    pre_abort  = 1'b0;
    post_abort = 1'b0;
    sc         = 1'b0;
    nbytes     = 2'd0;
    d.byte0    = in_r.data_byte;
    d.byte1    = size_high_byte;
    d.finish   = 1'b0;

    if (in_r.first_byte || parse_phase != hrd_pkg::PH_IDLE) begin
      if (in_r.first_byte) begin
        if (parse_phase != hrd_pkg::PH_IDLE) begin
          pre_abort = nal_open_next;
          nal_open_next = 1'b0;
          fragment_run_dropped_next = 1'b1;
        end
        parse_phase_next = hrd_pkg::PH_IDLE;
      end

      unique case (parse_phase_next) inside
        hrd_pkg::PH_IDLE: begin
          if (ptype != hrd_pkg::TypeFrag && nal_open_next) begin
            pre_abort = 1'b1;
            nal_open_next = 1'b0;
            fragment_run_dropped_next = 1'b1;
          end
          if (ptype < hrd_pkg::TypeAggr) begin
            sc = 1'b1;
            nbytes = 2'd1;
            nal_open_next = 1'b1;
            parse_phase_next = hrd_pkg::PH_SINGLE;
          end else if (ptype == hrd_pkg::TypeAggr) begin
            parse_phase_next = hrd_pkg::PH_AP_HDR1;
          end else if (ptype == hrd_pkg::TypeFrag) begin
            payload_header_first_next = in_r.data_byte;
            parse_phase_next = hrd_pkg::PH_FU_HDR1;
          end else begin
            parse_phase_next = hrd_pkg::PH_SKIP;
          end
        end
        hrd_pkg::PH_SINGLE: begin
          nbytes = 2'd1;
        end
        hrd_pkg::PH_AP_HDR1: begin
          parse_phase_next = hrd_pkg::PH_AP_NEXT;
        end
        hrd_pkg::PH_AP_NEXT: begin
          if (donl_enabled) begin
            parse_phase_next = hrd_pkg::PH_AP_DONL_LO;
          end else begin
            size_high_byte_next = in_r.data_byte;
            parse_phase_next = hrd_pkg::PH_AP_SIZE_LO;
          end
        end
        hrd_pkg::PH_AP_DONL_LO: begin
          parse_phase_next = hrd_pkg::PH_AP_SIZE_HI;
        end
        hrd_pkg::PH_AP_SIZE_HI: begin
          size_high_byte_next = in_r.data_byte;
          parse_phase_next = hrd_pkg::PH_AP_SIZE_LO;
        end
        hrd_pkg::PH_AP_SIZE_LO: begin
          if (size == 16'd0) begin
            sc = 1'b1;
            d.finish = 1'b1;
            parse_phase_next = hrd_pkg::PH_AP_NEXT;
          end else if (!in_r.last_byte) begin
            sc = 1'b1;
            nal_open_next = 1'b1;
            nal_bytes_left_next = size;
            parse_phase_next = hrd_pkg::PH_AP_NAL;
          end
        end
        hrd_pkg::PH_AP_NAL: begin
          nbytes = 2'd1;
          nal_bytes_left_next = nal_bytes_left - 16'd1;
          if (nal_bytes_left_next == 16'd0) begin
            d.finish = 1'b1;
            nal_open_next = 1'b0;
            parse_phase_next = hrd_pkg::PH_AP_NEXT;
          end
        end
        hrd_pkg::PH_FU_HDR1: begin
          size_high_byte_next = in_r.data_byte;
          parse_phase_next = hrd_pkg::PH_FU_HEADER;
        end
        hrd_pkg::PH_FU_HEADER: begin
          if (!in_r.last_byte) begin
            if (in_r.data_byte[7]) begin
              pre_abort = nal_open_next;
              sc = 1'b1;
              nbytes = 2'd2;
              d.byte0 = {1'b0, in_r.data_byte[5:0], 1'b0} |
                        (payload_header_first & hrd_pkg::HdrKeepMask);
              nal_open_next = 1'b1;
              fragment_run_dropped_next = 1'b0;
              fragment_end_seen_next = in_r.data_byte[6];
              parse_phase_next = fu_next;
            end else if (fragment_run_dropped || !nal_open) begin
              parse_phase_next = hrd_pkg::PH_SKIP;
            end else if (in_r.seq_num != 16'(previous_seq + 16'd1)) begin
              pre_abort = 1'b1;
              nal_open_next = 1'b0;
              fragment_run_dropped_next = 1'b1;
              parse_phase_next = hrd_pkg::PH_SKIP;
            end else begin
              fragment_end_seen_next = in_r.data_byte[6];
              parse_phase_next = fu_next;
            end
          end
        end
        hrd_pkg::PH_FU_DONL_HI: begin
          parse_phase_next = hrd_pkg::PH_FU_DONL_LO;
        end
        hrd_pkg::PH_FU_DONL_LO: begin
          parse_phase_next = hrd_pkg::PH_FU_FIRST;
        end
        hrd_pkg::PH_FU_FIRST, hrd_pkg::PH_FU_DATA: begin
          nbytes = 2'd1;
          parse_phase_next = hrd_pkg::PH_FU_DATA;
        end
        default: begin
        end
      endcase

      if (in_r.last_byte) begin
        unique case (parse_phase_next) inside
          hrd_pkg::PH_SINGLE: begin
            d.finish = 1'b1;
            nal_open_next = 1'b0;
          end
          hrd_pkg::PH_AP_NEXT, hrd_pkg::PH_SKIP: begin
          end
          hrd_pkg::PH_FU_DATA: begin
            if (fragment_end_seen_next) begin
              d.finish = 1'b1;
              nal_open_next = 1'b0;
              fragment_run_dropped_next = 1'b1;
            end
          end
          default: begin
            post_abort = nal_open_next;
            nal_open_next = 1'b0;
            fragment_run_dropped_next = 1'b1;
          end
        endcase
        previous_seq_next = in_r.seq_num;
        parse_phase_next = hrd_pkg::PH_IDLE;
      end
    end

    d.slots = {post_abort, nbytes == 2'd2, nbytes != 2'd0, sc, sc, sc, sc, pre_abort};
    desc = d;
    if (!in_valid) begin
      desc.slots = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase          <= hrd_pkg::PH_IDLE;
      nal_bytes_left       <= '0;
      size_high_byte       <= '0;
      payload_header_first <= '0;
      fragment_end_seen    <= 1'b0;
      nal_open             <= 1'b0;
      fragment_run_dropped <= 1'b1;
      previous_seq         <= '0;
    end else if (move) begin
      parse_phase          <= parse_phase_next;
      nal_bytes_left       <= nal_bytes_left_next;
      size_high_byte       <= size_high_byte_next;
      payload_header_first <= payload_header_first_next;
      fragment_end_seen    <= fragment_end_seen_next;
      nal_open             <= nal_open_next;
      fragment_run_dropped <= fragment_run_dropped_next;
      previous_seq         <= previous_seq_next;
    end
  end

endmodule

[hw/rtl/hrd_emitter.sv]
// Result register and serializer: walks a request's result slots, one per cycle while strm_stall is low.
// Depends on hrd_pkg.
module hrd_emitter (
  input  logic           clk,
  input  logic           rst,
  input  hrd_pkg::desc_t desc,
  output logic           ready,
  output logic           strm_valid,
  input  logic           strm_stall,
  output hrd_pkg::out_t  strm
);

  logic [hrd_pkg::NumSlots-1:0] mask;
  logic [hrd_pkg::NumSlots-1:0] sel;
  logic [hrd_pkg::NumSlots-1:0] rem;
  logic [hrd_pkg::NumSlots-1:0] mask_next;
  logic [7:0]                   byte0;
  logic [7:0]                   byte1;
  logic                         finish;
  logic                         is_last;
  logic                         is_abort;

  assign sel        = mask & (~mask + 1'b1);
  assign rem        = mask & ~sel;
  assign is_last    = (rem == '0);
  assign is_abort   = sel[hrd_pkg::SlotPre] || sel[hrd_pkg::SlotPost];
  assign strm_valid = (mask != '0);
  assign mask_next  = (strm_valid && !strm_stall) ? rem : mask;
  assign ready      = (mask_next == '0);

  always_comb begin
    strm.byte_valid = strm_valid && !is_abort;
    strm.nal_abort  = is_abort;
    strm.nal_begin  = sel[hrd_pkg::SlotSc0];
    strm.nal_finish = finish && is_last && !is_abort;
    strm.last       = is_last;
    if (sel[hrd_pkg::SlotSc3]) begin
      strm.out_byte = hrd_pkg::StartCodeLast;
    end else if (sel[hrd_pkg::SlotByte0]) begin
      strm.out_byte = byte0;
    end else if (sel[hrd_pkg::SlotByte1]) begin
      strm.out_byte = byte1;
    end else begin
      strm.out_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (ready) begin
      mask <= desc.slots;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      byte0  <= desc.byte0;
      byte1  <= desc.byte1;
      finish <= desc.finish;
    end
  end

endmodule

[hw/rtl/h265_rtp_depacketizer.sv]
// H.265 RTP payload bytes in, Annex-B byte stream with NAL begin/finish/abort marks out.
// A request is held in the parser's input register, and its first result is shown from the emitter's result register.
// Throughput: one request per cycle while each gives at most one result and the output is not
// stalled; a request with k results (start code expansion, up to 7) holds the input until its last result is taken.
// Reset (rst, synchronous): parser idle, fragment run dropped, DONL off, no result held.
module h265_rtp_depacketizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          pkt_valid,
  output logic          pkt_stall,
  input  hrd_pkg::in_t  pkt,
  output logic          strm_valid,
  input  logic          strm_stall,
  output hrd_pkg::out_t strm
);

  hrd_pkg::desc_t desc;
  logic           ready;

  hrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .ready     (ready),
    .desc      (desc)
  );

  hrd_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .desc       (desc),
    .ready      (ready),
    .strm_valid (strm_valid),
    .strm_stall (strm_stall),
    .strm       (strm)
  );

endmodule

[hw/rtl/hrd_checker.sv]
// Port-level checks for the depacketizer output stream, bound to the top level.
// Depends on hrd_pkg and h265_rtp_depacketizer.
module hrd_checker (
  input logic          clk,
  input logic          rst,
  input logic          strm_valid,
  input logic          strm_stall,
  input hrd_pkg::out_t strm
);

  a_abort_alone: assert property (@(posedge clk) disable iff (rst)
    strm_valid && strm.nal_abort |->
      !strm.byte_valid && !strm.nal_begin && !strm.nal_finish)
    else $error("abort carries stream data");

  a_begin_zero: assert property (@(posedge clk) disable iff (rst)
    strm_valid && strm.nal_begin |->
      strm.byte_valid && strm.out_byte == 8'h00 && !strm.last && !strm.nal_finish)
    else $error("bad first start code byte");

  a_begin_follow: assert property (@(posedge clk) disable iff (rst)
    strm_valid && strm.nal_begin && !strm_stall |=>
      strm_valid && strm.out_byte == 8'h00 && !strm.nal_begin && !strm.nal_abort)
    else $error("start code broken");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    strm_valid && strm_stall |=> strm_valid && $stable(strm))
    else $error("stalled result changed");

endmodule

bind h265_rtp_depacketizer hrd_checker u_hrd_checker (
  .clk        (clk),
  .rst        (rst),
  .strm_valid (strm_valid),
  .strm_stall (strm_stall),
  .strm       (strm)
);
